FILE: design/tbdd_pkg.sv
`default_nettype none

package tbdd_pkg;

  // Number of channels with their own tracking state, and the index width.
  localparam int CHANNELS = 16;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths.
  localparam int CH_W     = 4;
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 8;
  localparam int SHIFT_W  = 4;
  localparam int CNT_W    = 8;
  localparam int SCALED_W = SAMPLE_W + GAIN_W;

  // Configuration port geometry.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;

  // Largest averaging shift that is honored.
  localparam logic [SHIFT_W-1:0] MAX_SHIFT = SHIFT_W'(10);

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_ON_LEVEL       = 3'd0,
    REG_OFF_LEVEL      = 3'd1,
    REG_NOISE_GAIN     = 3'd2,
    REG_BASELINE_SHIFT = 3'd3,
    REG_NOISE_SHIFT    = 3'd4,
    REG_DEBOUNCE_LEN   = 3'd5
  } reg_idx_e;

  // Register values as seen by the datapath.
  typedef struct packed {
    logic [SAMPLE_W-1:0] on_level;
    logic [SAMPLE_W-1:0] off_level;
    logic [GAIN_W-1:0]   noise_gain;
    logic [SHIFT_W-1:0]  baseline_shift;
    logic [SHIFT_W-1:0]  noise_shift;
    logic [CNT_W-1:0]    debounce_len;
  } cfg_t;

  // Shift setting clamped to the supported range.
  function automatic logic [SHIFT_W-1:0] eff_shift(input logic [SHIFT_W-1:0] s);
    return (s > MAX_SHIFT) ? MAX_SHIFT : s;
  endfunction

  // cur + floor((tgt - cur) / 2^sh); the result lies between cur and tgt.
  function automatic logic [SAMPLE_W-1:0] ema_step(input logic [SAMPLE_W-1:0] cur,
                                                   input logic [SAMPLE_W-1:0] tgt,
                                                   input logic [SHIFT_W-1:0]  sh);
    logic signed [SAMPLE_W:0]   diff;
    logic signed [SAMPLE_W:0]   step;
    logic signed [SAMPLE_W+1:0] sum;
    diff = $signed({1'b0, tgt}) - $signed({1'b0, cur});
    step = diff >>> sh;
    sum  = $signed({2'b00, cur}) + $signed({step[SAMPLE_W], step});
    return sum[SAMPLE_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/tbdd_if.sv
`default_nettype none

// Sample channel: one touch reading with its channel number.
interface tbdd_in_if;
  import tbdd_pkg::*;
  logic                valid;
  logic                ready;
  logic [CH_W-1:0]     channel;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, channel, sample, input ready);
  modport sink   (input valid, channel, sample, output ready);
endinterface

// Result channel: debounced touch state and deviation of one sample.
interface tbdd_out_if;
  import tbdd_pkg::*;
  logic                valid;
  logic                ready;
  logic [CH_W-1:0]     channel_out;
  logic                touched;
  logic [SAMPLE_W-1:0] deviation;
  modport source (output valid, channel_out, touched, deviation, input ready);
  modport sink   (input valid, channel_out, touched, deviation, output ready);
endinterface

`default_nettype wire

FILE: design/tbdd_cfg.sv
`default_nettype none

module tbdd_cfg
  import tbdd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  // Register writes in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_level       <= SAMPLE_W'(90);
      cfg_q.off_level      <= SAMPLE_W'(55);
      cfg_q.noise_gain     <= GAIN_W'(6);
      cfg_q.baseline_shift <= SHIFT_W'(6);
      cfg_q.noise_shift    <= SHIFT_W'(4);
      cfg_q.debounce_len   <= CNT_W'(3);
    end else if (wr_en) begin
      unique case (idx)
        REG_ON_LEVEL:       cfg_q.on_level       <= pwdata[SAMPLE_W-1:0];
        REG_OFF_LEVEL:      cfg_q.off_level      <= pwdata[SAMPLE_W-1:0];
        REG_NOISE_GAIN:     cfg_q.noise_gain     <= pwdata[GAIN_W-1:0];
        REG_BASELINE_SHIFT: cfg_q.baseline_shift <= pwdata[SHIFT_W-1:0];
        REG_NOISE_SHIFT:    cfg_q.noise_shift    <= pwdata[SHIFT_W-1:0];
        REG_DEBOUNCE_LEN:   cfg_q.debounce_len   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (idx)
      REG_ON_LEVEL:       prdata = APB_DATA_W'(cfg_q.on_level);
      REG_OFF_LEVEL:      prdata = APB_DATA_W'(cfg_q.off_level);
      REG_NOISE_GAIN:     prdata = APB_DATA_W'(cfg_q.noise_gain);
      REG_BASELINE_SHIFT: prdata = APB_DATA_W'(cfg_q.baseline_shift);
      REG_NOISE_SHIFT:    prdata = APB_DATA_W'(cfg_q.noise_shift);
      REG_DEBOUNCE_LEN:   prdata = APB_DATA_W'(cfg_q.debounce_len);
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/touch_baseline_debounce_detector.sv
// Touch detector with per-channel baseline tracking and debounce. Each sample
// transaction enters an input register and its result leaves through a result
// register; one sample is accepted every cycle as long as the result side
// keeps taking results. All per-channel state (baseline, noise, seeded and
// touched flags, press and release counters) lives in flip-flops that are
// read and updated in the same cycle, so samples of the same channel may
// follow each other without gaps. There is no clearing pass: reset clears all
// channel state at once. The first sample of a channel seeds its baseline and
// reports deviation 0 and not touched. Registers: on_level (0x00), off_level
// (0x04), noise_gain (0x08), baseline_shift (0x0C), noise_shift (0x10),
// debounce_len (0x14); write them only while no sample is in flight.
`default_nettype none

module touch_baseline_debounce_detector
  import tbdd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  tbdd_in_if.sink                    samp_i,
  tbdd_out_if.source                 res_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t cfg;

  tbdd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register.
  logic                s1_valid_q;
  logic [CH_W-1:0]     s1_ch_q;
  logic [SAMPLE_W-1:0] s1_sample_q;

  // Result register.
  logic                out_valid_q;
  logic [CH_W-1:0]     out_ch_q;
  logic                out_touched_q;
  logic [SAMPLE_W-1:0] out_dev_q;

  // Per-channel state.
  logic [SAMPLE_W-1:0] base_q    [CHANNELS];
  logic [SAMPLE_W-1:0] noise_q   [CHANNELS];
  logic [CNT_W-1:0]    press_q   [CHANNELS];
  logic [CNT_W-1:0]    release_q [CHANNELS];
  logic [CHANNELS-1:0] seeded_q;
  logic [CHANNELS-1:0] touched_q;

  logic s1_fire;
  logic in_fire;

  assign s1_fire      = s1_valid_q && (!out_valid_q || res_o.ready);
  assign samp_i.ready = !s1_valid_q || s1_fire;
  assign in_fire      = samp_i.valid && samp_i.ready;

  // Input register: holds the sample being worked on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (samp_i.ready) begin
      s1_valid_q <= samp_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ch_q     <= samp_i.channel;
      s1_sample_q <= samp_i.sample;
    end
  end

  // Datapath for the sample in the input register.
  logic [CH_IDX_W-1:0]   idx;
  logic                  in_range;
  logic [SAMPLE_W-1:0]   base;
  logic [SAMPLE_W-1:0]   noise;
  logic [CNT_W-1:0]      press;
  logic [CNT_W-1:0]      rel;
  logic [SAMPLE_W-1:0]   dev;
  logic [SCALED_W-1:0]   scaled;
  logic [SCALED_W:0]     on_sum;
  logic [SCALED_W:0]     off_sum;
  logic [SAMPLE_W-1:0]   on_th;
  logic [SAMPLE_W-1:0]   off_lv;
  logic [SAMPLE_W-1:0]   off_th;
  logic [CNT_W-1:0]      deb;
  logic [CNT_W-1:0]      press_inc;
  logic [CNT_W-1:0]      rel_inc;
  logic                  touched_d;
  logic [CNT_W-1:0]      press_d;
  logic [CNT_W-1:0]      rel_d;
  logic [SAMPLE_W-1:0]   base_d;
  logic [SAMPLE_W-1:0]   noise_d;
  logic                  res_touched;
  logic [SAMPLE_W-1:0]   res_dev;
  logic                  st_we;

  always_comb begin
    idx      = s1_ch_q[CH_IDX_W-1:0];
    in_range = (int'(s1_ch_q) < CHANNELS);
    base     = base_q[idx];
    noise    = noise_q[idx];
    press    = press_q[idx];
    rel      = release_q[idx];

    // Deviation and noise-scaled thresholds, saturated to 16 bits.
    dev     = (s1_sample_q >= base) ? (s1_sample_q - base) : (base - s1_sample_q);
    scaled  = noise * cfg.noise_gain;
    on_sum  = (SCALED_W+1)'(cfg.on_level) + (SCALED_W+1)'(scaled);
    on_th   = (on_sum[SCALED_W:SAMPLE_W] != '0) ? '1 : on_sum[SAMPLE_W-1:0];
    off_lv  = (cfg.off_level > cfg.on_level) ? cfg.on_level : cfg.off_level;
    off_sum = (SCALED_W+1)'(off_lv) + (SCALED_W+1)'(scaled >> 1);
    off_th  = (off_sum[SCALED_W:SAMPLE_W] != '0) ? '1 : off_sum[SAMPLE_W-1:0];
    deb     = (cfg.debounce_len == '0) ? CNT_W'(1) : cfg.debounce_len;

    press_inc = (press == '1) ? press : press + CNT_W'(1);
    rel_inc   = (rel == '1) ? rel : rel + CNT_W'(1);

    // Debounce decision.
    touched_d = touched_q[idx];
    press_d   = press;
    rel_d     = rel;
    if (!touched_q[idx]) begin
      if (dev >= on_th) begin
        press_d = press_inc;
        if (press_inc >= deb) begin
          touched_d = 1'b1;
          press_d   = '0;
          rel_d     = '0;
        end
      end else begin
        press_d = '0;
      end
    end else begin
      if (dev <= off_th) begin
        rel_d = rel_inc;
        if (rel_inc >= deb) begin
          touched_d = 1'b0;
          press_d   = '0;
          rel_d     = '0;
        end
      end else begin
        rel_d = '0;
      end
    end

    // Tracking only follows the sample while the channel stays untouched.
    base_d  = base;
    noise_d = noise;
    if (!touched_d) begin
      base_d  = ema_step(base, s1_sample_q, eff_shift(cfg.baseline_shift));
      noise_d = ema_step(noise, dev, eff_shift(cfg.noise_shift));
    end

    // A seeding sample loads the baseline and clears everything else.
    if (!seeded_q[idx]) begin
      touched_d = 1'b0;
      press_d   = '0;
      rel_d     = '0;
      base_d    = s1_sample_q;
      noise_d   = '0;
    end

    res_touched = in_range && seeded_q[idx] && touched_d;
    res_dev     = (in_range && seeded_q[idx]) ? dev : '0;
    st_we       = s1_fire && in_range;
  end

  // Channel state update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '{default: '0};
      noise_q   <= '{default: '0};
      press_q   <= '{default: '0};
      release_q <= '{default: '0};
      seeded_q  <= '0;
      touched_q <= '0;
    end else if (st_we) begin
      base_q[idx]    <= base_d;
      noise_q[idx]   <= noise_d;
      press_q[idx]   <= press_d;
      release_q[idx] <= rel_d;
      seeded_q[idx]  <= 1'b1;
      touched_q[idx] <= touched_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_ch_q      <= s1_ch_q;
      out_touched_q <= res_touched;
      out_dev_q     <= res_dev;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.channel_out = out_ch_q;
  assign res_o.touched     = out_touched_q;
  assign res_o.deviation   = out_dev_q;

  // Input stalls only when both registers hold a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !samp_i.ready |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free stage");

  // Once seeded, a channel stays seeded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($countones(seeded_q) >= $past($countones(seeded_q))))
    else $error("seeded channel lost its seed");

  // A touched channel never carries a pending press count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && in_range && touched_q[idx]) |-> (press_q[idx] == '0))
    else $error("press count pending on a touched channel");

endmodule

`default_nettype wire

FILE: tb/touch_baseline_debounce_detector_chk.sv
`timescale 1ns / 100ps

module touch_baseline_debounce_detector_chk
  import tbdd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  tbdd_in_if                         samp_mon,
  tbdd_out_if                        res_mon,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic                  pready,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output int                         mismatch_count,
  output int                         pending_results,
  output int                         result_count,
  output int                         touched_count
);

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic                touched;
    logic [SAMPLE_W-1:0] deviation;
  } touch_result_t;

  // Results predicted for accepted samples, oldest first.
  touch_result_t expected_touch_q[$];

  // Shadow copy of the register file.
  logic [SAMPLE_W-1:0] on_lvl;
  logic [SAMPLE_W-1:0] off_lvl;
  logic [GAIN_W-1:0]   gain;
  logic [SHIFT_W-1:0]  base_sh;
  logic [SHIFT_W-1:0]  noise_sh;
  logic [CNT_W-1:0]    debounce;

  // Shadow copy of the per-channel tracking state.
  logic [SAMPLE_W-1:0] baseline_mem [CHANNELS];
  logic [SAMPLE_W-1:0] noise_mem    [CHANNELS];
  logic                seeded_mem   [CHANNELS];
  logic                touch_mem    [CHANNELS];
  logic [CNT_W-1:0]    press_cnt    [CHANNELS];
  logic [CNT_W-1:0]    release_cnt  [CHANNELS];

  // Moves cur toward tgt by the floored difference divided by 2^sh.
  function automatic logic [SAMPLE_W-1:0] follow_avg(input int cur, input int tgt,
                                                     input logic [SHIFT_W-1:0] sh);
    int amount;
    int shift;
    int nxt;
    shift  = (sh > MAX_SHIFT) ? int'(MAX_SHIFT) : int'(sh);
    amount = (tgt - cur) >>> shift;
    nxt    = cur + amount;
    if (nxt < 0) nxt = 0;
    if (nxt > 65535) nxt = 65535;
    return SAMPLE_W'(nxt);
  endfunction

  // Runs one sample through the shadow state and returns what the block must report.
  function automatic touch_result_t track_sample(input logic [CH_W-1:0] ch,
                                                 input logic [SAMPLE_W-1:0] smp);
    touch_result_t res;
    int base;
    int dev;
    int scaled;
    int on_th;
    int off_base;
    int off_th;
    int need;
    res = '{channel: ch, touched: 1'b0, deviation: '0};
    if (int'(ch) >= CHANNELS) return res;
    if (!seeded_mem[ch]) begin
      seeded_mem[ch]   = 1'b1;
      baseline_mem[ch] = smp;
      noise_mem[ch]    = '0;
      press_cnt[ch]    = '0;
      release_cnt[ch]  = '0;
      touch_mem[ch]    = 1'b0;
      return res;
    end
    base     = int'(baseline_mem[ch]);
    dev      = (int'(smp) >= base) ? int'(smp) - base : base - int'(smp);
    scaled   = int'(noise_mem[ch]) * int'(gain);
    on_th    = int'(on_lvl) + scaled;
    if (on_th > 65535) on_th = 65535;
    off_base = (off_lvl > on_lvl) ? int'(on_lvl) : int'(off_lvl);
    off_th   = off_base + scaled / 2;
    if (off_th > 65535) off_th = 65535;
    need     = (debounce == '0) ? 1 : int'(debounce);

    // Debounce: count consecutive qualifying samples toward a state change.
    if (!touch_mem[ch]) begin
      if (dev >= on_th) begin
        if (press_cnt[ch] != '1) press_cnt[ch] = press_cnt[ch] + 1'b1;
        if (int'(press_cnt[ch]) >= need) begin
          touch_mem[ch]   = 1'b1;
          press_cnt[ch]   = '0;
          release_cnt[ch] = '0;
        end
      end else begin
        press_cnt[ch] = '0;
      end
    end else begin
      if (dev <= off_th) begin
        if (release_cnt[ch] != '1) release_cnt[ch] = release_cnt[ch] + 1'b1;
        if (int'(release_cnt[ch]) >= need) begin
          touch_mem[ch]   = 1'b0;
          release_cnt[ch] = '0;
          press_cnt[ch]   = '0;
        end
      end else begin
        release_cnt[ch] = '0;
      end
    end

    // Baseline and noise only track while the channel is released.
    if (!touch_mem[ch]) begin
      baseline_mem[ch] = follow_avg(base, int'(smp), base_sh);
      noise_mem[ch]    = follow_avg(int'(noise_mem[ch]), dev, noise_sh);
    end
    res.touched   = touch_mem[ch];
    res.deviation = SAMPLE_W'(dev);
    return res;
  endfunction

  // Register writes, sample predictions and result comparison.
  always @(posedge clk_i or negedge rst_ni) begin
    touch_result_t want;
    if (!rst_ni) begin
      on_lvl   = 16'd90;
      off_lvl  = 16'd55;
      gain     = 8'd6;
      base_sh  = 4'd6;
      noise_sh = 4'd4;
      debounce = 8'd3;
      for (int i = 0; i < CHANNELS; i++) begin
        baseline_mem[i] = '0;
        noise_mem[i]    = '0;
        seeded_mem[i]   = 1'b0;
        touch_mem[i]    = 1'b0;
        press_cnt[i]    = '0;
        release_cnt[i]  = '0;
      end
      expected_touch_q.delete();
      mismatch_count  = 0;
      pending_results = 0;
      result_count    = 0;
      touched_count   = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[APB_ADDR_W-1:2]))
          REG_ON_LEVEL:       on_lvl   = pwdata[SAMPLE_W-1:0];
          REG_OFF_LEVEL:      off_lvl  = pwdata[SAMPLE_W-1:0];
          REG_NOISE_GAIN:     gain     = pwdata[GAIN_W-1:0];
          REG_BASELINE_SHIFT: base_sh  = pwdata[SHIFT_W-1:0];
          REG_NOISE_SHIFT:    noise_sh = pwdata[SHIFT_W-1:0];
          REG_DEBOUNCE_LEN:   debounce = pwdata[CNT_W-1:0];
          default: ;
        endcase
      end

      if (samp_mon.valid && samp_mon.ready) begin
        expected_touch_q.push_back(track_sample(samp_mon.channel, samp_mon.sample));
      end

      if (res_mon.valid && res_mon.ready) begin
        result_count++;
        if (res_mon.touched === 1'b1) touched_count++;
        if (expected_touch_q.size() == 0) begin
          $display("%0t: result transaction with nothing expected, actual ch %0d touched %0d dev %0d",
                   $time, res_mon.channel_out, res_mon.touched, res_mon.deviation);
          mismatch_count++;
        end else begin
          want = expected_touch_q.pop_front();
          if (res_mon.channel_out !== want.channel) begin
            $display("%0t: channel_out mismatch, expected %0d, actual %0d",
                     $time, want.channel, res_mon.channel_out);
            mismatch_count++;
          end
          if (res_mon.touched !== want.touched) begin
            $display("%0t: touched mismatch on ch %0d, expected %0d, actual %0d",
                     $time, want.channel, want.touched, res_mon.touched);
            mismatch_count++;
          end
          if (res_mon.deviation !== want.deviation) begin
            $display("%0t: deviation mismatch on ch %0d, expected %0d, actual %0d",
                     $time, want.channel, want.deviation, res_mon.deviation);
            mismatch_count++;
          end
        end
      end
      pending_results = expected_touch_q.size();
    end
  end

endmodule

FILE: tb/touch_baseline_debounce_detector_tb.sv
`timescale 1ns / 100ps

module touch_baseline_debounce_detector_tb;
  import tbdd_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 200;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatch_count;
  int pending_results;
  int result_count;
  int touched_count;
  int samples_sent;
  int settings_applied;
  int idle_cycles;

  // Idling controls for the sender and the receiver.
  bit gap_en;
  bit stall_en;
  bit long_hold_req;

  // Per-channel finger model for the random part.
  int chan_level   [CHANNELS];
  bit chan_pressed [CHANNELS];
  int chan_left    [CHANNELS];
  int chan_amp     [CHANNELS];
  bit chan_up      [CHANNELS];

  tbdd_in_if  samp_if ();
  tbdd_out_if res_if ();

  touch_baseline_debounce_detector dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .samp_i  (samp_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  touch_baseline_debounce_detector_chk u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .samp_mon        (samp_if),
    .res_mon         (res_if),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .result_count    (result_count),
    .touched_count   (touched_count)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (samp_if.valid && samp_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    bit hold_done;
    hold_done    = 1'b0;
    res_if.ready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (long_hold_req && !hold_done) begin
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_done = 1'b1;
      end else if (stall_en && $urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
      end
    end
  end

  // Offers one sample and returns at the falling edge after its transaction.
  task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
    if (gap_en && $urandom_range(0, 4) == 0) begin
      samp_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    samp_if.valid   <= 1'b1;
    samp_if.channel <= ch;
    samp_if.sample  <= smp;
    @(posedge clk_i);
    while (!samp_if.ready) @(posedge clk_i);
    samples_sent++;
    @(negedge clk_i);
  endtask

  // Picks a channel and a reading from press, release and noise patterns.
  task automatic send_random_sample();
    logic [CH_W-1:0] ch;
    int              val;
    int              jitter;
    if ($urandom_range(0, 9) < 7) ch = CH_W'($urandom_range(0, 3));
    else ch = CH_W'($urandom_range(0, CHANNELS - 1));
    if (chan_left[ch] == 0) begin
      chan_pressed[ch] = !chan_pressed[ch];
      chan_left[ch]    = $urandom_range(1, 12);
      chan_up[ch]      = $urandom_range(0, 1);
      if ($urandom_range(0, 3) == 0) chan_amp[ch] = $urandom_range(1000, 30000);
      else chan_amp[ch] = $urandom_range(60, 600);
    end
    chan_left[ch]--;
    jitter = $urandom_range(0, 8);
    if ($urandom_range(0, 9) == 0) begin
      val = $urandom_range(0, 65535);
    end else if (chan_pressed[ch]) begin
      val = chan_up[ch] ? chan_level[ch] + chan_amp[ch] : chan_level[ch] - chan_amp[ch];
    end else begin
      val = chan_level[ch] + $urandom_range(0, 2 * jitter) - jitter;
    end
    if (val < 0) val = 0;
    if (val > 65535) val = 65535;
    send_sample(ch, SAMPLE_W'(val));
  endtask

  // One APB write: setup cycle, then access cycle.
  task automatic reg_write(input reg_idx_e idx, input logic [APB_DATA_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drains the block, then loads a full register setting.
  task automatic apply_setting(input int on_l, input int off_l, input int gn,
                               input int bsh, input int nsh, input int deb);
    samp_if.valid <= 1'b0;
    wait (pending_results == 0);
    repeat (4) @(negedge clk_i);
    reg_write(REG_ON_LEVEL, APB_DATA_W'(on_l));
    reg_write(REG_OFF_LEVEL, APB_DATA_W'(off_l));
    reg_write(REG_NOISE_GAIN, APB_DATA_W'(gn));
    reg_write(REG_BASELINE_SHIFT, APB_DATA_W'(bsh));
    reg_write(REG_NOISE_SHIFT, APB_DATA_W'(nsh));
    reg_write(REG_DEBOUNCE_LEN, APB_DATA_W'(deb));
    settings_applied++;
  endtask

  initial begin
    samp_if.valid   = 1'b0;
    samp_if.channel = '0;
    samp_if.sample  = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    samples_sent     = 0;
    settings_applied = 1;
    gap_en           = 1'b1;
    stall_en         = 1'b1;
    long_hold_req    = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      case ($urandom_range(0, 5))
        0:       chan_level[i] = 0;
        1:       chan_level[i] = 65535;
        default: chan_level[i] = $urandom_range(0, 65535);
      endcase
      chan_pressed[i] = 1'b1;
      chan_left[i]    = 0;
      chan_amp[i]     = 0;
      chan_up[i]      = 1'b0;
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part under the reset setting: full-scale swings, seeding,
    // a debounced press and release, and a one-count deviation.
    send_sample(4'd15, 16'hFFFF);
    repeat (4) send_sample(4'd15, 16'h0000);
    send_sample(4'd0, 16'h0000);
    send_sample(4'd0, 16'hFFFF);
    repeat (3) send_sample(4'd3, 16'd1000);
    repeat (4) send_sample(4'd3, 16'd1200);
    repeat (4) send_sample(4'd3, 16'd1000);
    send_sample(4'd7, 16'h8000);
    send_sample(4'd7, 16'h7FFF);

    // Moderate thresholds; includes a long result-side hold-off.
    apply_setting(200, 100, 2, 3, 2, 2);
    repeat (40) send_random_sample();
    gap_en        = 1'b0;
    long_hold_req = 1'b1;
    repeat (40) send_random_sample();
    gap_en = 1'b1;
    repeat (40) send_random_sample();

    // Everything at its lowest; debounce of zero acts as one.
    apply_setting(0, 0, 0, 0, 0, 0);
    repeat (90) send_random_sample();

    // Thresholds and gain at their top, slowest honored shifts.
    apply_setting(65535, 65535, 255, 10, 10, 1);
    repeat (70) send_random_sample();

    // Off level above on level, shifts beyond the honored range.
    apply_setting(1000, 60000, 1, 15, 11, 255);
    repeat (70) send_random_sample();

    // Back to the reset values, with no idling on either side.
    apply_setting(90, 55, 6, 6, 4, 3);
    gap_en   = 1'b0;
    stall_en = 1'b0;
    repeat (130) send_random_sample();

    samp_if.valid <= 1'b0;
    wait (pending_results == 0);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d samples across %0d register settings; %0d results checked, %0d touched.",
             samples_sent, settings_applied, result_count, touched_count);
    $display("Included a long result hold-off, zero debounce and averaging shifts above ten.");
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
